FILE: src/link_state_route_table_assert.svh
// assertion macros for the link-state route table
// expects clk_i and rst_ni in the scope of use
`ifndef LINK_STATE_ROUTE_TABLE_ASSERT_SVH
`define LINK_STATE_ROUTE_TABLE_ASSERT_SVH

// clocked assertion, off while in reset
`define LSRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lsrt: assertion failed");

// clocked assertion that also holds during reset
`define LSRT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("lsrt: assertion failed");

`endif

FILE: src/lsrt_pkg.sv
// types and codes for the link-state route table
// no dependencies
package lsrt_pkg;

  localparam int unsigned NODE_W = 6;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned COST_W = 24;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_COMPUTE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_ROUTE = 2'd0;
  localparam logic [1:0] STATUS_NO_EDGES = 2'd1;
  localparam logic [1:0] STATUS_ACCEPT = 2'd2;
  localparam logic [1:0] STATUS_FULL = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X_ORD,
    ST_X_NODE,
    ST_X_LOAD,
    ST_E_RD,
    ST_E_CHK,
    ST_E_UPD,
    ST_M_RUN,
    ST_M_END,
    ST_O_ORD,
    ST_O_NODE,
    ST_O_OUT,
    ST_ERR
  } state_e;

endpackage

FILE: src/lsrt_if.sv
// valid/ready channel interfaces for the route table input and result
// depends on nothing but the field widths written here
interface lsrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  node;
  logic [5:0]  neighbor;
  logic [15:0] edge_cost;

  modport source (output valid, func, node, neighbor, edge_cost, input ready);
  modport sink (input valid, func, node, neighbor, edge_cost, output ready);
endinterface

interface lsrt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  destination;
  logic [23:0] path_cost;
  logic [5:0]  next_hop;
  logic        last;

  modport source (output valid, status, destination, path_cost, next_hop, last,
                  input ready);
  modport sink (input valid, status, destination, path_cost, next_hop, last,
                output ready);
endinterface

FILE: src/link_state_route_table.sv
// Link-state route table. Add and clear items may follow back to back as long
// as each result is taken; each gives one result transfer. A compute item runs a
// shortest-path search from the named node over the edge memory, which has a
// single read port: for every node that is confirmed, every stored edge is
// read in turn, the targets of the edges that leave that node are read and,
// where the cost improves, updated, and every node entry is scanned;
// every route entry is then read out of the order and node memories. No input
// is taken during a compute. No clearing pass is needed after reset.
// depends on lsrt_pkg, lsrt_if and link_state_route_table_assert.svh
`include "link_state_route_table_assert.svh"

module link_state_route_table #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned MAX_EDGES = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  lsrt_in_if.sink    in_i,
  lsrt_out_if.source out_o
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned EW = $clog2(MAX_EDGES);
  localparam int unsigned CW = lsrt_pkg::COST_W;
  localparam int unsigned GW = lsrt_pkg::WEIGHT_W;
  localparam int unsigned DW = lsrt_pkg::NODE_W;
  localparam int unsigned EDW = 2 * DW + GW;
  localparam int unsigned NDW = CW + DW + NW;

  // memories
  logic [EDW-1:0] edge_mem [MAX_EDGES];
  logic [NDW-1:0] node_mem [MAX_NODES];
  logic [NW-1:0]  ord_mem  [MAX_NODES];

  logic           edge_we, edge_re;
  logic [EW-1:0]  edge_waddr, edge_raddr;
  logic [EDW-1:0] edge_wdata, edge_rdata;
  logic           node_we, node_re;
  logic [NW-1:0]  node_waddr, node_raddr;
  logic [NDW-1:0] node_wdata, node_rdata;
  logic           ord_we, ord_re;
  logic [NW-1:0]  ord_waddr, ord_raddr, ord_wdata, ord_rdata;

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    if (edge_re) edge_rdata <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    if (node_re) node_rdata <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    if (ord_re) ord_rdata <= ord_mem[ord_raddr];
  end

  // control and datapath registers
  lsrt_pkg::state_e state_q, state_d;
  logic [EW:0]          ecnt_q, ecnt_d, e_q, e_d;
  logic [MAX_NODES-1:0] tent_q, tent_d, conf_q, conf_d;
  logic [NW:0]          nconf_q, nconf_d, ei_q, ei_d, scan_q, scan_d;
  logic [NW-1:0]        pos_q, pos_d, stamp_q, stamp_d;
  logic [NW-1:0]        cp_q, cp_d, nb_q, nb_d, pick_q, pick_d, ridx_q, ridx_d;
  logic [NW-1:0]        dst_q, dst_d;
  logic [DW-1:0]        err_q, err_d;
  logic [CW-1:0]        cpc_q, cpc_d, bestc_q, bestc_d;
  logic [DW-1:0]        cph_q, cph_d;
  logic [NW-1:0]        bests_q, bests_d;
  logic                 any_q, any_d, found_q, found_d, rvld_q, rvld_d;

  logic        ovld_q, out_load, out_free;
  logic [1:0]  ost_q, ost_d;
  logic [DW-1:0] odst_q, odst_d, ohop_q, ohop_d;
  logic [CW-1:0] ocost_q, ocost_d;
  logic        olast_q, olast_d;

  // decoded memory words
  logic [DW-1:0] e_org, e_tgt;
  logic [GW-1:0] e_wgt;
  logic [CW-1:0] n_cost;
  logic [DW-1:0] n_hop;
  logic [NW-1:0] n_stamp;
  logic [CW:0]   sum;
  logic [CW-1:0] nc;
  logic [DW-1:0] nhop;
  logic          in_fire, add_bad, add_fire;

  assign {e_org, e_tgt, e_wgt} = edge_rdata;
  assign {n_cost, n_hop, n_stamp} = node_rdata;
  assign sum = {1'b0, cpc_q} + (CW + 1)'(e_wgt);
  assign nc = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
  assign nhop = (cph_q == '0) ? DW'(nb_q) : cph_q;

  assign out_free = !ovld_q || out_o.ready;
  assign in_i.ready = (state_q == lsrt_pkg::ST_IDLE) && out_free;
  assign in_fire = in_i.valid && in_i.ready;
  assign add_bad = (ecnt_q == (EW + 1)'(MAX_EDGES)) || (32'(in_i.node) >= MAX_NODES) ||
                   (32'(in_i.neighbor) >= MAX_NODES);
  assign add_fire = in_fire && (in_i.func == lsrt_pkg::FUNC_ADD) && !add_bad;

  always_comb begin
    state_d = state_q;
    ecnt_d = ecnt_q; e_d = e_q; tent_d = tent_q; conf_d = conf_q;
    nconf_d = nconf_q; ei_d = ei_q; scan_d = scan_q; pos_d = pos_q;
    stamp_d = stamp_q; cp_d = cp_q; nb_d = nb_q; pick_d = pick_q; ridx_d = ridx_q;
    dst_d = dst_q; err_d = err_q; cpc_d = cpc_q; cph_d = cph_q;
    bestc_d = bestc_q; bests_d = bests_q; any_d = any_q; found_d = found_q;
    rvld_d = rvld_q;
    edge_we = 1'b0; edge_re = 1'b0; edge_waddr = ecnt_q[EW-1:0]; edge_raddr = e_q[EW-1:0];
    edge_wdata = {in_i.node, in_i.neighbor, in_i.edge_cost};
    node_we = 1'b0; node_re = 1'b0; node_waddr = nb_q; node_raddr = nb_q;
    node_wdata = '0;
    ord_we = 1'b0; ord_re = 1'b0; ord_waddr = '0; ord_raddr = pos_q; ord_wdata = '0;
    out_load = 1'b0;
    ost_d = ost_q; odst_d = odst_q; ocost_d = ocost_q; ohop_d = ohop_q; olast_d = olast_q;

    unique case (state_q)
      lsrt_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority case (in_i.func)
            lsrt_pkg::FUNC_ADD: begin
              out_load = 1'b1;
              ost_d = lsrt_pkg::STATUS_FULL; odst_d = '0; ocost_d = '0;
              ohop_d = '0; olast_d = 1'b1;
              if (!add_bad) begin
                edge_we = 1'b1;
                ecnt_d = ecnt_q + 1'b1;
                ost_d = lsrt_pkg::STATUS_ACCEPT;
              end
            end
            lsrt_pkg::FUNC_COMPUTE: begin
              if (32'(in_i.node) >= MAX_NODES) begin
                err_d = in_i.node;
                state_d = lsrt_pkg::ST_ERR;
              end else begin
                tent_d = '0;
                conf_d = '0;
                conf_d[NW'(in_i.node)] = 1'b1;
                node_we = 1'b1; node_waddr = NW'(in_i.node); node_wdata = '0;
                ord_we = 1'b1; ord_waddr = '0; ord_wdata = NW'(in_i.node);
                nconf_d = (NW + 1)'(1); pos_d = '0; stamp_d = '0;
                state_d = lsrt_pkg::ST_X_ORD;
              end
            end
            lsrt_pkg::FUNC_CLEAR: begin
              ecnt_d = '0;
              out_load = 1'b1;
              ost_d = lsrt_pkg::STATUS_ACCEPT; odst_d = '0; ocost_d = '0;
              ohop_d = '0; olast_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      lsrt_pkg::ST_ERR: begin
        if (out_free) begin
          out_load = 1'b1;
          ost_d = lsrt_pkg::STATUS_NO_EDGES; odst_d = err_q; ocost_d = '0;
          ohop_d = '0; olast_d = 1'b1;
          state_d = lsrt_pkg::ST_IDLE;
        end
      end
      lsrt_pkg::ST_X_ORD: begin
        ord_re = 1'b1; ord_raddr = pos_q;
        state_d = lsrt_pkg::ST_X_NODE;
      end
      lsrt_pkg::ST_X_NODE: begin
        cp_d = ord_rdata;
        node_re = 1'b1; node_raddr = ord_rdata;
        state_d = lsrt_pkg::ST_X_LOAD;
      end
      lsrt_pkg::ST_X_LOAD: begin
        cpc_d = n_cost; cph_d = n_hop;
        e_d = '0; any_d = 1'b0;
        state_d = lsrt_pkg::ST_E_RD;
      end
      lsrt_pkg::ST_E_RD: begin
        if (e_q == ecnt_q) begin
          if (any_q) begin
            scan_d = '0; rvld_d = 1'b0; found_d = 1'b0;
            state_d = lsrt_pkg::ST_M_RUN;
          end else begin
            err_d = DW'(cp_q);
            state_d = lsrt_pkg::ST_ERR;
          end
        end else begin
          edge_re = 1'b1; edge_raddr = e_q[EW-1:0];
          e_d = e_q + 1'b1;
          state_d = lsrt_pkg::ST_E_CHK;
        end
      end
      lsrt_pkg::ST_E_CHK: begin
        state_d = lsrt_pkg::ST_E_RD;
        if (NW'(e_org) == cp_q) begin
          any_d = 1'b1;
          nb_d = NW'(e_tgt);
          node_re = 1'b1; node_raddr = NW'(e_tgt);
          state_d = lsrt_pkg::ST_E_UPD;
        end
      end
      lsrt_pkg::ST_E_UPD: begin
        node_waddr = nb_q;
        if (!conf_q[nb_q] && !tent_q[nb_q]) begin
          node_we = 1'b1; node_wdata = {nc, nhop, stamp_q};
          tent_d[nb_q] = 1'b1;
          stamp_d = stamp_q + 1'b1;
        end else if (tent_q[nb_q] && (nc < n_cost)) begin
          node_we = 1'b1; node_wdata = {nc, nhop, n_stamp};
        end
        state_d = lsrt_pkg::ST_E_RD;
      end
      lsrt_pkg::ST_M_RUN: begin
        if (rvld_q && tent_q[ridx_q]) begin
          if (!found_q || (n_cost < bestc_q) ||
              ((n_cost == bestc_q) && (n_stamp < bests_q))) begin
            found_d = 1'b1; pick_d = ridx_q; bestc_d = n_cost; bests_d = n_stamp;
          end
        end
        if (scan_q != (NW + 1)'(MAX_NODES)) begin
          node_re = 1'b1; node_raddr = scan_q[NW-1:0];
          ridx_d = scan_q[NW-1:0]; rvld_d = 1'b1;
          scan_d = scan_q + 1'b1;
        end else begin
          rvld_d = 1'b0;
          if (!rvld_q) state_d = lsrt_pkg::ST_M_END;
        end
      end
      lsrt_pkg::ST_M_END: begin
        if (!found_q) begin
          ei_d = '0;
          state_d = lsrt_pkg::ST_O_ORD;
        end else begin
          tent_d[pick_q] = 1'b0;
          conf_d[pick_q] = 1'b1;
          ord_we = 1'b1; ord_waddr = nconf_q[NW-1:0]; ord_wdata = pick_q;
          nconf_d = nconf_q + 1'b1;
          pos_d = pos_q + 1'b1;
          state_d = lsrt_pkg::ST_X_ORD;
        end
      end
      lsrt_pkg::ST_O_ORD: begin
        if (ei_q == nconf_q) begin
          state_d = lsrt_pkg::ST_IDLE;
        end else begin
          ord_re = 1'b1; ord_raddr = ei_q[NW-1:0];
          state_d = lsrt_pkg::ST_O_NODE;
        end
      end
      lsrt_pkg::ST_O_NODE: begin
        dst_d = ord_rdata;
        node_re = 1'b1; node_raddr = ord_rdata;
        state_d = lsrt_pkg::ST_O_OUT;
      end
      lsrt_pkg::ST_O_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          ost_d = lsrt_pkg::STATUS_ROUTE; odst_d = DW'(dst_q); ocost_d = n_cost;
          ohop_d = n_hop; olast_d = (ei_q + 1'b1) == nconf_q;
          ei_d = ei_q + 1'b1;
          state_d = lsrt_pkg::ST_O_ORD;
        end
      end
      default: state_d = lsrt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsrt_pkg::ST_IDLE;
      ecnt_q <= '0;
      tent_q <= '0;
      conf_q <= '0;
      ovld_q <= 1'b0;
      rvld_q <= 1'b0;
      found_q <= 1'b0;
      any_q <= 1'b0;
      nconf_q <= '0;
    end else begin
      state_q <= state_d;
      ecnt_q <= ecnt_d;
      tent_q <= tent_d;
      conf_q <= conf_d;
      rvld_q <= rvld_d;
      found_q <= found_d;
      any_q <= any_d;
      nconf_q <= nconf_d;
      if (out_load) ovld_q <= 1'b1;
      else if (out_o.ready) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d; ei_q <= ei_d; scan_q <= scan_d; pos_q <= pos_d; stamp_q <= stamp_d;
    cp_q <= cp_d; nb_q <= nb_d; pick_q <= pick_d; ridx_q <= ridx_d; dst_q <= dst_d;
    err_q <= err_d; cpc_q <= cpc_d; cph_q <= cph_d; bestc_q <= bestc_d;
    bests_q <= bests_d;
    ost_q <= ost_d; odst_q <= odst_d; ocost_q <= ocost_d; ohop_q <= ohop_d;
    olast_q <= olast_d;
  end

  assign out_o.valid = ovld_q;
  assign out_o.status = ost_q;
  assign out_o.destination = odst_q;
  assign out_o.path_cost = ocost_q;
  assign out_o.next_hop = ohop_q;
  assign out_o.last = olast_q;

  `LSRT_ASSERT(a_ready_idle, in_i.ready |-> (state_q == lsrt_pkg::ST_IDLE))
  `LSRT_ASSERT(a_marks_disjoint, (tent_q & conf_q) == '0)
  `LSRT_ASSERT(a_nconf_bound, nconf_q <= (NW + 1)'(MAX_NODES))
  `LSRT_ASSERT(a_add_count, add_fire |=> (ecnt_q == $past(ecnt_q) + 1'b1))
  `LSRT_ASSERT(a_no_load_full, (out_load && ovld_q) |-> out_o.ready)

endmodule
